@@ rtl/core/sha2_pkg.sv @@
// ----------------------------------------------------------------------------
// sha2_pkg
// constants and helpers shared by the sha-224/256 digest core
// ----------------------------------------------------------------------------
`default_nettype none
package sha2_pkg;

  localparam int unsigned WordW = 32;

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] iv_word(input logic mode, input logic [2:0] idx);
    logic [31:0] v;
    v = 32'h0;
    if (mode) begin
      case (idx)
        3'd0: v = 32'h6a09e667;
        3'd1: v = 32'hbb67ae85;
        3'd2: v = 32'h3c6ef372;
        3'd3: v = 32'ha54ff53a;
        3'd4: v = 32'h510e527f;
        3'd5: v = 32'h9b05688c;
        3'd6: v = 32'h1f83d9ab;
        default: v = 32'h5be0cd19;
      endcase
    end else begin
      case (idx)
        3'd0: v = 32'hc1059ed8;
        3'd1: v = 32'h367cd507;
        3'd2: v = 32'h3070dd17;
        3'd3: v = 32'hf70e5939;
        3'd4: v = 32'hffc00b31;
        3'd5: v = 32'h68581511;
        3'd6: v = 32'h64f98fa7;
        default: v = 32'hbefa4fa4;
      endcase
    end
    return v;
  endfunction

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/sha2_ram.sv @@
// ----------------------------------------------------------------------------
// sha2_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module sha2_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ rtl/core/sha224_sha256_digest.sv @@
// ----------------------------------------------------------------------------
// sha224_sha256_digest
// byte-streaming sha-224 / sha-256 digest engine with built-in padding
// ----------------------------------------------------------------------------
// One byte is taken per beat and the core is ready while idle and no mode
// write is offered, so bytes can flow at one per cycle. Each full 64-byte
// block then holds the input during compression (a prime state, one round
// per cycle, schedule words from a 16-entry message ram with a registered
// read, pipelined one round ahead) and a fold into the chain. On tlast the
// core pads the message byte by byte (up to 72 bytes of fill including the
// length) and compresses one or two final blocks, then streams seven or
// eight digest words on m_axis; the input waits until the last digest word
// has been taken. Writing the mode register starts a fresh message.
`default_nettype none
module sha224_sha256_digest (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i,     // digest_mode
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tuser,   // byte_present
  input  wire logic        s_axis_tlast,   // message_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // digest_word
  output logic             m_axis_tlast    // digest_last
);
  import sha2_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StPrime, StRound, StFold, StPad, StLen, StOut
  } state_e;

  state_e      state_q;
  logic        mode_q;
  logic [31:0] chain_q [8];
  logic [31:0] wv_q [8];
  logic [63:0] bits_q, len_q;
  logic [5:0]  pos_q;
  logic [6:0]  rnd_q;
  logic [3:0]  lcnt_q;     // length bytes written, eight once the block is complete
  logic        final_q, padded_q;
  logic [3:0]  ocnt_q;
  logic [31:0] word_q;     // byte-assembly copy of the word being filled
  logic [31:0] win_q [16];

  // message ram holds the window; register copy kept for the schedule taps
  logic        ram_we;
  logic [3:0]  ram_wa, ram_ra;
  logic [31:0] ram_wd, ram_rd;

  sha2_ram #(.Width(32), .Depth(16)) u_msg (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(ram_wd),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );

  // byte write path
  logic       put_en;
  logic [7:0] put_b;
  logic [31:0] word_new;
  always_comb begin
    word_new = word_q;
    case (pos_q[1:0])
      2'd0: word_new = {put_b, 24'h0};
      2'd1: word_new[23:16] = put_b;
      2'd2: word_new[15:8] = put_b;
      default: word_new[7:0] = put_b;
    endcase
  end

  // schedule
  logic [3:0]  ri;
  logic [31:0] w2, w15, w7, w16, wsch, wt;
  assign ri  = rnd_q[3:0];
  assign w2  = win_q[ri - 4'd2];
  assign w15 = win_q[ri - 4'd15];
  assign w7  = win_q[ri - 4'd7];
  assign w16 = ram_rd;
  assign wsch = (ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10)) + w7
              + (ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3)) + w16;
  assign wt = rnd_q[6:4] == 3'd0 ? ram_rd : wsch;

  logic [31:0] t1, t2, e, a;
  assign e  = wv_q[4];
  assign a  = wv_q[0];
  assign t1 = wv_q[7] + RoundK[rnd_q[5:0]] + wt
            + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & wv_q[5]) ^ (~e & wv_q[6]));
  assign t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
            + ((a & wv_q[1]) ^ (a & wv_q[2]) ^ (wv_q[1] & wv_q[2]));

  logic s_acc;
  assign s_axis_tready = state_q == StIdle && !cfg_valid_i;
  assign cfg_ready_o   = state_q == StIdle;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    put_en = 1'b0;
    put_b  = s_axis_tdata;
    if (state_q == StIdle && s_acc && s_axis_tuser) begin
      put_en = 1'b1;
    end else if (state_q == StPad) begin
      put_en = 1'b1;
      put_b  = padded_q ? 8'h00 : PadByte;
    end else if (state_q == StLen) begin
      put_en = 1'b1;
      put_b  = len_q[63:56];
    end
  end

  always_comb begin
    ram_we = put_en;
    ram_wa = pos_q[5:2];
    ram_wd = word_new;
    ram_ra = rnd_q[3:0];
    if (state_q == StRound && rnd_q[6:4] != 3'd0) begin
      ram_we = 1'b1;
      ram_wa = ri;
      ram_wd = wsch;
    end
    if (state_q == StPrime) begin
      ram_ra = 4'd0;
    end else if (state_q == StRound) begin
      ram_ra = ri + 4'd1;
    end
  end

  assign m_axis_tvalid = state_q == StOut;
  assign m_axis_tdata  = chain_q[ocnt_q[2:0]];
  assign m_axis_tlast  = ocnt_q == (mode_q ? 4'd7 : 4'd6);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      mode_q   <= 1'b1;
      bits_q   <= '0;
      len_q    <= '0;
      pos_q    <= '0;
      rnd_q    <= '0;
      final_q  <= 1'b0;
      padded_q <= 1'b0;
      ocnt_q   <= '0;
      lcnt_q   <= '0;
      word_q   <= '0;
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= iv_word(1'b1, 3'(i));
        wv_q[i]    <= '0;
      end
      for (int i = 0; i < 16; i++) win_q[i] <= '0;
    end else begin
      if (put_en) begin
        word_q <= word_new;
        win_q[pos_q[5:2]] <= word_new;
        pos_q <= pos_q + 6'd1;
      end
      case (state_q)
        StIdle: begin
          if (cfg_valid_i) begin
            mode_q <= cfg_data_i;
            bits_q <= '0;
            pos_q  <= '0;
            for (int i = 0; i < 8; i++) chain_q[i] <= iv_word(cfg_data_i, 3'(i));
          end else if (s_acc) begin
            final_q  <= s_axis_tlast;
            padded_q <= 1'b0;
            len_q    <= bits_q + (s_axis_tuser ? 64'd8 : 64'd0);
            if (s_axis_tuser) bits_q <= bits_q + 64'd8;
            if (s_axis_tuser && pos_q == 6'd63) begin
              state_q <= StPrime;
            end else if (s_axis_tlast) begin
              state_q <= StPad;
            end
          end
        end
        StPrime: begin
          rnd_q <= '0;
          for (int i = 0; i < 8; i++) wv_q[i] <= chain_q[i];
          state_q <= StRound;
        end
        StRound: begin
          if (rnd_q[6:4] != 3'd0) win_q[ri] <= wsch;
          wv_q[7] <= wv_q[6];
          wv_q[6] <= wv_q[5];
          wv_q[5] <= e;
          wv_q[4] <= wv_q[3] + t1;
          wv_q[3] <= wv_q[2];
          wv_q[2] <= wv_q[1];
          wv_q[1] <= a;
          wv_q[0] <= t1 + t2;
          rnd_q <= rnd_q + 7'd1;
          if (rnd_q == 7'd63) state_q <= StFold;
        end
        StFold: begin
          rnd_q <= '0;
          for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + wv_q[i];
          if (!final_q) begin
            state_q <= StIdle;
          end else if (lcnt_q == 4'd8) begin
            // the block just folded carried the length
            state_q <= StOut;
            ocnt_q  <= '0;
          end else begin
            state_q <= StPad;
          end
        end
        StPad: begin
          padded_q <= 1'b1;
          lcnt_q   <= '0;
          if (pos_q == 6'd63) begin
            state_q <= StPrime;
          end else if (pos_q == 6'd55) begin
            state_q <= StLen;
          end
        end
        StLen: begin
          len_q  <= {len_q[55:0], 8'h00};
          lcnt_q <= lcnt_q + 4'd1;
          if (lcnt_q == 4'd7) state_q <= StPrime;
        end
        StOut: begin
          if (m_axis_tready) begin
            ocnt_q <= ocnt_q + 4'd1;
            if (m_axis_tlast) begin
              state_q  <= StIdle;
              bits_q   <= '0;
              pos_q    <= '0;
              final_q  <= 1'b0;
              padded_q <= 1'b0;
              lcnt_q   <= '0;
              for (int i = 0; i < 8; i++) chain_q[i] <= iv_word(mode_q, 3'(i));
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRound && rnd_q == 7'd63 |=> state_q == StFold)
    else $error("round count overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input open during digest output");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ocnt_q <= 4'd7)
    else $error("digest word count out of range");
endmodule
`default_nettype wire
